/* hdl/pcic_pkg.sv */
// Shared types, constants and helpers for the clamped-integrator PID core.
`timescale 1ns / 1ps
`default_nettype none
package pcic_pkg;

    localparam int ERR_W      = 16;
    localparam int ACC_W_DEF  = 32;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 32;
    localparam int RATE_W     = 24;
    localparam int DRIVE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Serial multiply / divide unit
    localparam int MD_W       = 64;
    localparam int MD_B_W     = 28;
    localparam int MUL_STEPS  = 24;
    localparam int DIV_STEPS  = 64;

    localparam logic [MD_W-1:0] TERM_BOUND = 64'h2000_0000_0000_0000;
    localparam logic [MD_W-1:0] MAG_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic signed [GAIN_W-1:0] KP_RST    = 24'sd65536;
    localparam logic signed [GAIN_W-1:0] KI_RST    = 24'sd0;
    localparam logic signed [GAIN_W-1:0] KD_RST    = 24'sd0;
    localparam logic [LIMIT_W-1:0]       LIMIT_RST = 32'hFFFF_FFFF;
    localparam logic [RATE_W-1:0]        RATE_RST  = 24'd256;

    typedef struct packed {
        logic                    command;
        logic signed [ERR_W-1:0] error_sample;
        logic                    sample_invalid;
    } t_in;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_value;
        logic                      drive_saturated;
    } t_out;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_INTEG_LIMIT = 3'd3,
        REG_SAMPLE_RATE = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_BMUL  = 3'd0,
        OP_BDIV  = 3'd1,
        OP_PMUL  = 3'd2,
        OP_IMUL  = 3'd3,
        OP_IDIV  = 3'd4,
        OP_DMUL1 = 3'd5,
        OP_DMUL2 = 3'd6
    } t_op;

    typedef enum logic [11:0] {
        S_BCHK  = 12'b0000_0000_0001,
        S_BMUL  = 12'b0000_0000_0010,
        S_BDIV  = 12'b0000_0000_0100,
        S_IDLE  = 12'b0000_0000_1000,
        S_ACC   = 12'b0000_0001_0000,
        S_CLAMP = 12'b0000_0010_0000,
        S_PMUL  = 12'b0000_0100_0000,
        S_IMUL  = 12'b0000_1000_0000,
        S_IDIV  = 12'b0001_0000_0000,
        S_DMUL1 = 12'b0010_0000_0000,
        S_DMUL2 = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    typedef struct packed {
        logic cfg_we;
        logic load_in;
        logic acc_step;
        logic clamp_step;
        logic op_start;
        t_op  op;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic op_done;
        logic in_zero;
        logic need_bound;
    } t_dp_sts;

    // Magnitude of a signed gain, zero-extended to the unit's operand width
    function automatic logic [MD_B_W-1:0] gain_mag(input logic signed [GAIN_W-1:0] g);
        logic signed [GAIN_W:0] x;
        begin
            x = (GAIN_W+1)'(g);
            if (x < 0) begin
                x = -x;
            end
            return MD_B_W'($unsigned(x));
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/pcic_muldiv.sv */
// Shared bit-serial unsigned multiplier (saturating) and restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module pcic_muldiv
    import pcic_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_is_div,
    input  wire logic [MD_W-1:0]   i_a,
    input  wire logic [MD_B_W-1:0] i_b,
    output logic                   o_done,
    output logic [MD_W-1:0]        o_result
);

    localparam int CNT_W  = $clog2(DIV_STEPS);
    localparam int PROD_W = MD_W + MUL_STEPS;

    logic                r_busy;
    logic                r_done;
    logic                r_div;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-1:0]   r_ma;
    logic [MUL_STEPS-1:0] r_mb;
    logic [MD_W-1:0]     r_q;
    logic [MD_B_W:0]     r_rem;
    logic [MD_B_W-1:0]   r_d;

    logic [MD_B_W:0]     rem_sh;
    logic                q_bit;

    always_comb begin
        rem_sh = {r_rem[MD_B_W-1:0], r_q[MD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_is_div ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_is_div;
            r_acc <= '0;
            r_ma  <= PROD_W'(i_a);
            r_mb  <= i_b[MUL_STEPS-1:0];
            r_q   <= i_a;
            r_rem <= '0;
            r_d   <= i_b;
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= q_bit ? (rem_sh - {1'b0, r_d}) : rem_sh;
                r_q   <= {r_q[MD_W-2:0], q_bit};
            end else begin
                if (r_mb[0]) begin
                    r_acc <= r_acc + r_ma;
                end
                r_ma <= {r_ma[PROD_W-2:0], 1'b0};
                r_mb <= {1'b0, r_mb[MUL_STEPS-1:1]};
            end
        end
    end

    always_comb begin
        o_done = r_done;
        if (r_div) begin
            o_result = r_q;
        end else if (r_acc > PROD_W'(MAG_MAX)) begin
            o_result = MAG_MAX;
        end else begin
            o_result = r_acc[MD_W-1:0];
        end
    end

endmodule
`default_nettype wire

/* hdl/pcic_datapath.sv */
// Datapath: config registers, integrator, term accumulation and output register.
`timescale 1ns / 1ps
`default_nettype none
module pcic_datapath
    import pcic_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_W_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire t_in                   i_in,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out                       o_out
);

    localparam logic [MD_W-1:0] ACC_MAX_U = (64'd1 << (ACC_WIDTH - 1)) - 64'd1;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX_S = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN_S = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [GAIN_W-1:0]    r_kp, r_ki, r_kd;
    logic [LIMIT_W-1:0]          r_limit;
    logic [RATE_W-1:0]           r_rate;
    logic signed [ACC_WIDTH-1:0] r_integ;
    logic [ACC_WIDTH-1:0]        r_lim;
    logic signed [ERR_W-1:0]     r_last;
    logic signed [ERR_W-1:0]     r_e;
    logic signed [ERR_W:0]       r_diff;
    logic signed [MD_W-1:0]      r_sum;
    t_op                         r_op;
    t_out                        r_out;

    logic [RATE_W-1:0]           rate_eff;
    logic [MD_B_W-1:0]           rate16;
    logic                        ki_pos, lim_on;
    logic signed [ACC_WIDTH-1:0] lim_s, neg_lim;
    logic signed [ACC_WIDTH:0]   add_s;
    logic signed [ACC_WIDTH-1:0] add_sat, clamp_v;
    logic signed [ERR_W:0]       e_x, e_abs;
    logic signed [ERR_W+1:0]     d_x, d_abs;
    logic signed [MD_W:0]        i_x, i_abs;
    logic                        md_done;
    logic [MD_W-1:0]             md_res;
    logic [MD_W-1:0]             md_a;
    logic [MD_B_W-1:0]           md_b;
    logic                        md_div;
    logic [MD_W-1:0]             term_mag;
    logic                        term_neg;
    logic signed [MD_W-1:0]      term_val;
    logic                        term_add;

    assign rate_eff = (r_rate == '0) ? RATE_W'(1) : r_rate;
    assign rate16   = {rate_eff, 4'b0000};
    assign ki_pos   = !r_ki[GAIN_W-1] && (r_ki != '0);
    assign lim_on   = (r_limit != '1);
    assign lim_s    = $signed(r_lim);
    assign neg_lim  = -lim_s;

    // Saturating integrator add
    always_comb begin
        add_s = (ACC_WIDTH+1)'(r_integ) + (ACC_WIDTH+1)'(r_e);
        if (add_s[ACC_WIDTH] != add_s[ACC_WIDTH-1]) begin
            add_sat = add_s[ACC_WIDTH] ? ACC_MIN_S : ACC_MAX_S;
        end else begin
            add_sat = add_s[ACC_WIDTH-1:0];
        end
    end

    always_comb begin
        clamp_v = r_integ;
        if (!ki_pos) begin
            clamp_v = '0;
        end else if (lim_on) begin
            if (r_integ > lim_s) begin
                clamp_v = lim_s;
            end else if (r_integ < neg_lim) begin
                clamp_v = neg_lim;
            end
        end
    end

    // Operand magnitudes
    always_comb begin
        e_x   = (ERR_W+1)'(r_e);
        e_abs = (e_x < 0) ? -e_x : e_x;
        d_x   = (ERR_W+2)'(r_diff);
        d_abs = (d_x < 0) ? -d_x : d_x;
        i_x   = (MD_W+1)'(r_integ);
        i_abs = (i_x < 0) ? -i_x : i_x;
    end

    // Operand select; chained ops take the previous product straight off the unit
    always_comb begin
        md_a   = '0;
        md_b   = '0;
        md_div = 1'b0;
        case (i_cmd.op)
            OP_BMUL: begin
                md_a = MD_W'(r_limit);
                md_b = MD_B_W'(rate_eff);
            end
            OP_BDIV: begin
                md_a   = {md_res[MD_W-5:0], 4'b0000};
                md_b   = gain_mag(r_ki);
                md_div = 1'b1;
            end
            OP_PMUL: begin
                md_a = MD_W'($unsigned(e_abs));
                md_b = gain_mag(r_kp);
            end
            OP_IMUL: begin
                md_a = i_abs[MD_W-1:0];
                md_b = gain_mag(r_ki);
            end
            OP_IDIV: begin
                md_a   = md_res;
                md_b   = rate16;
                md_div = 1'b1;
            end
            OP_DMUL1: begin
                md_a = MD_W'($unsigned(d_abs));
                md_b = gain_mag(r_kd);
            end
            OP_DMUL2: begin
                md_a = md_res;
                md_b = MD_B_W'(rate_eff);
            end
            default: begin
                md_a = '0;
            end
        endcase
    end

    pcic_muldiv u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.op_start),
        .i_is_div (md_div),
        .i_a      (md_a),
        .i_b      (md_b),
        .o_done   (md_done),
        .o_result (md_res)
    );

    // Term shaping on completion of P, I and D ops
    always_comb begin
        term_mag = '0;
        term_neg = 1'b0;
        term_add = 1'b0;
        case (r_op)
            OP_PMUL: begin
                term_mag = md_res >> 12;
                term_neg = r_e[ERR_W-1] ^ r_kp[GAIN_W-1];
                term_add = 1'b1;
            end
            OP_IDIV: begin
                term_mag = (md_res > TERM_BOUND) ? TERM_BOUND : md_res;
                term_neg = r_integ[ACC_WIDTH-1];
                term_add = 1'b1;
            end
            OP_DMUL2: begin
                term_mag = ((md_res >> 20) > TERM_BOUND) ? TERM_BOUND : (md_res >> 20);
                term_neg = r_diff[ERR_W] ^ r_kd[GAIN_W-1];
                term_add = 1'b1;
            end
            default: begin
                term_add = 1'b0;
            end
        endcase
        term_val = term_neg ? -$signed(term_mag) : $signed(term_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= KP_RST;
            r_ki    <= KI_RST;
            r_kd    <= KD_RST;
            r_limit <= LIMIT_RST;
            r_rate  <= RATE_RST;
            r_integ <= '0;
            r_last  <= '0;
        end else begin
            if (i_cmd.cfg_we) begin
                unique case (i_cfg_index)
                    REG_PROP_GAIN:   r_kp    <= $signed(i_cfg_data[GAIN_W-1:0]);
                    REG_INTEG_GAIN:  r_ki    <= $signed(i_cfg_data[GAIN_W-1:0]);
                    REG_DERIV_GAIN:  r_kd    <= $signed(i_cfg_data[GAIN_W-1:0]);
                    REG_INTEG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                    REG_SAMPLE_RATE: r_rate  <= i_cfg_data[RATE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_in && i_in.command) begin
                r_integ <= '0;
            end
            if (i_cmd.acc_step) begin
                r_integ <= add_sat;
                r_last  <= r_e;
            end
            if (i_cmd.clamp_step) begin
                r_integ <= clamp_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_e   <= i_in.error_sample;
            r_sum <= '0;
        end else if (md_done && term_add) begin
            r_sum <= r_sum - term_val;
        end
        if (i_cmd.acc_step) begin
            r_diff <= (ERR_W+1)'(r_e) - (ERR_W+1)'(r_last);
        end
        if (i_cmd.op_start) begin
            r_op <= i_cmd.op;
        end
        if (md_done && (r_op == OP_BDIV)) begin
            r_lim <= (md_res > ACC_MAX_U) ? ACC_MAX_U[ACC_WIDTH-1:0]
                                          : md_res[ACC_WIDTH-1:0];
        end
        if (i_cmd.out_load) begin
            if (r_sum > 64'sd2147483647) begin
                r_out.drive_value     <= 32'sh7FFF_FFFF;
                r_out.drive_saturated <= 1'b1;
            end else if (r_sum < -64'sd2147483648) begin
                r_out.drive_value     <= 32'sh8000_0000;
                r_out.drive_saturated <= 1'b1;
            end else begin
                r_out.drive_value     <= r_sum[DRIVE_W-1:0];
                r_out.drive_saturated <= 1'b0;
            end
        end
    end

    assign o_out            = r_out;
    assign o_sts.op_done    = md_done;
    assign o_sts.in_zero    = i_in.command | i_in.sample_invalid;
    assign o_sts.need_bound = ki_pos & lim_on;

`ifndef SYNTHESIS
    a_invalid_keeps_integ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_in && i_in.sample_invalid && !i_in.command |=> $stable(r_integ))
        else $error("invalid sample changed the integral");

    a_cmd_clears_integ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_in && i_in.command |=> r_integ == '0)
        else $error("reset command did not clear the integral");

    a_clamp_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.clamp_step) && ki_pos && lim_on |->
            (r_integ <= lim_s) && (r_integ >= neg_lim))
        else $error("integral outside its clamp after clamp step");
`endif

endmodule
`default_nettype wire

/* hdl/pcic_ctrl.sv */
// Controller FSM: handshakes, bound recompute and per-sample op sequencing.
`timescale 1ns / 1ps
`default_nettype none
module pcic_ctrl
    import pcic_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire logic    i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_fire, cfg_fire, out_load, is_op;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_BCHK:  n_state = i_sts.need_bound ? S_BMUL : S_IDLE;
            S_BMUL:  if (i_sts.op_done) n_state = S_BDIV;
            S_BDIV:  if (i_sts.op_done) n_state = S_IDLE;
            S_IDLE: begin
                if (cfg_fire) begin
                    n_state = S_BCHK;
                end else if (in_fire) begin
                    n_state = i_sts.in_zero ? S_DONE : S_ACC;
                end
            end
            S_ACC:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_PMUL;
            S_PMUL:  if (i_sts.op_done) n_state = S_IMUL;
            S_IMUL:  if (i_sts.op_done) n_state = S_IDIV;
            S_IDIV:  if (i_sts.op_done) n_state = S_DMUL1;
            S_DMUL1: if (i_sts.op_done) n_state = S_DMUL2;
            S_DMUL2: if (i_sts.op_done) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_BCHK;
        endcase
    end

    // Each op state kicks the shared unit on entry
    always_comb begin
        is_op     = 1'b1;
        o_cmd.op  = OP_BMUL;
        unique case (n_state)
            S_BMUL:  o_cmd.op = OP_BMUL;
            S_BDIV:  o_cmd.op = OP_BDIV;
            S_PMUL:  o_cmd.op = OP_PMUL;
            S_IMUL:  o_cmd.op = OP_IMUL;
            S_IDIV:  o_cmd.op = OP_IDIV;
            S_DMUL1: o_cmd.op = OP_DMUL1;
            S_DMUL2: o_cmd.op = OP_DMUL2;
            default: is_op = 1'b0;
        endcase
        o_cmd.op_start   = is_op && (n_state != r_state);
        o_cmd.cfg_we     = cfg_fire;
        o_cmd.load_in    = in_fire;
        o_cmd.acc_step   = (r_state == S_ACC);
        o_cmd.clamp_step = (r_state == S_CLAMP);
        o_cmd.out_load   = out_load;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BCHK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_done_in_op_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.op_done |-> (r_state == S_BMUL) || (r_state == S_BDIV) ||
            (r_state == S_PMUL) || (r_state == S_IMUL) || (r_state == S_IDIV) ||
            (r_state == S_DMUL1) || (r_state == S_DMUL2))
        else $error("unit finished outside an op state");

    a_cfg_recomputes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> r_state == S_BCHK)
        else $error("config write did not trigger bound recompute");

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("output valid dropped while the receiver stalled");
`endif

endmodule
`default_nettype wire

/* hdl/pid_controller_clamped_integrator_core.sv */
// Top level of the negated PID controller with clamped integrator.
//
// Usage notes:
//  - Input channel (i_in_valid/o_in_ready, i_in): one word per error sample.
//    command=1 clears the integral and answers 0; sample_invalid=1 answers 0
//    and touches no state.
//  - A normal sample takes the integrator add and clamp steps, then runs
//    four 24-step multiplies and one 64-step divide on one shared bit-serial
//    multiply/divide unit, then the output load. The next sample is accepted
//    only after that load.
//  - Output channel (o_out_valid/i_out_ready, o_out): one word per input word.
//    The result sits in an output register, so a new sample is accepted while
//    the previous result waits; a stalled receiver holds the next result in
//    the final state until the register frees up.
//  - Config channel (i_cfg_valid/o_cfg_ready): write only while idle. Each
//    write recomputes the integral bound (L*rate*16/ki) when one applies,
//    during which no sample is accepted.
//  - Reset (i_rst_n low, synchronous): registers take their defaults, the
//    integral and last error clear, output valid drops.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_clamped_integrator_core
    import pcic_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_W_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // sample words in
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in,
    // drive words out
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out,
    // register writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencing, handshakes
    pcic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // arithmetic, state and result register
    pcic_datapath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in        (i_in),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
